>>> rtl/core/tbm_pkg.sv
// -----------------------------------------------------------------------------
// tbm_pkg
// Shared types, codes and reset values for the two-button mode UI.
// -----------------------------------------------------------------------------
package tbm_pkg;

   localparam int NUM_BANKS_DEF = 4;

   localparam int TICK_W     = 32;
   localparam int TOUCH_W    = 16;
   localparam int MODE_W     = 2;
   localparam int CMD_W      = 2;
   localparam int OUT_BANK_W = 2;
   localparam int LONG_W     = 3;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_TOUCH_THRESHOLD    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_PRESS_TICKS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS_TICKS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_BLINK_TICKS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_BLINK_TICKS   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_GAP_TICKS    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_TIMEOUT_TICKS = 3'd6;

   localparam logic [TOUCH_W-1:0] RST_TOUCH_THRESHOLD    = 16'd20;
   localparam logic [TICK_W-1:0]  RST_SHORT_PRESS_TICKS  = 32'd112500;
   localparam logic [TICK_W-1:0]  RST_LONG_PRESS_TICKS   = 32'd1500000;
   localparam logic [TICK_W-1:0]  RST_SHORT_BLINK_TICKS  = 32'd300000;
   localparam logic [TICK_W-1:0]  RST_LONG_BLINK_TICKS   = 32'd1125000;
   localparam logic [TICK_W-1:0]  RST_BLINK_GAP_TICKS    = 32'd1500000;
   localparam logic [TICK_W-1:0]  RST_IDLE_TIMEOUT_TICKS = 32'd45000000;

   typedef enum logic [MODE_W-1:0] {
      MODE_IDLE  = 2'd0,
      MODE_LOAD  = 2'd1,
      MODE_STORE = 2'd2
   } mode_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_NONE  = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_STORE = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [TOUCH_W-1:0] touch_threshold;
      logic [TICK_W-1:0]  short_press_ticks;
      logic [TICK_W-1:0]  long_press_ticks;
      logic [TICK_W-1:0]  short_blink_ticks;
      logic [TICK_W-1:0]  long_blink_ticks;
      logic [TICK_W-1:0]  blink_gap_ticks;
      logic [TICK_W-1:0]  idle_timeout_ticks;
   } cfg_type;

   typedef struct packed {
      mode_type           mode;
      logic [TICK_W-1:0]  last_activity;
      logic               press_a_down;
      logic [TICK_W-1:0]  press_a_start;
      logic               press_b_prev;
      logic               blink_active;
      logic [TICK_W-1:0]  blink_mark;
      logic [LONG_W-1:0]  long_left;
      logic               led_level;
   } core_state_type;

   typedef struct packed {
      logic                  led_on;
      cmd_type               transfer_cmd;
      logic [OUT_BANK_W-1:0] transfer_bank;
      logic [MODE_W-1:0]     cur_mode;
      logic [OUT_BANK_W-1:0] cur_bank;
   } result_type;

endpackage

>>> rtl/core/tbm_chan_if.sv
// -----------------------------------------------------------------------------
// tbm channel interfaces
// Valid/ready channels for touch samples and UI results.
// -----------------------------------------------------------------------------
interface tbm_req_if;
   import tbm_pkg::*;

   logic               valid;
   logic               ready;
   logic [TICK_W-1:0]  now_ticks;
   logic [TOUCH_W-1:0] touch_a;
   logic [TOUCH_W-1:0] touch_b;

   modport source (output valid, output now_ticks, output touch_a, output touch_b,
                   input ready);
   modport sink   (input valid, input now_ticks, input touch_a, input touch_b,
                   output ready);
endinterface

interface tbm_rsp_if;
   import tbm_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  led_on;
   logic [CMD_W-1:0]      transfer_cmd;
   logic [OUT_BANK_W-1:0] transfer_bank;
   logic [MODE_W-1:0]     cur_mode;
   logic [OUT_BANK_W-1:0] cur_bank;

   modport source (output valid, output led_on, output transfer_cmd,
                   output transfer_bank, output cur_mode, output cur_bank,
                   input ready);
   modport sink   (input valid, input led_on, input transfer_cmd,
                   input transfer_bank, input cur_mode, input cur_bank,
                   output ready);
endinterface

>>> rtl/core/tbm_csr.sv
// -----------------------------------------------------------------------------
// tbm_csr
// Configuration register file, write-only.
// -----------------------------------------------------------------------------
module tbm_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [tbm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tbm_pkg::CSR_DATA_W-1:0]  csr_data,
   output tbm_pkg::cfg_type                cfg
);
   import tbm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TOUCH_THRESHOLD:    cfg_in.touch_threshold    = csr_data[TOUCH_W-1:0];
            CSR_SHORT_PRESS_TICKS:  cfg_in.short_press_ticks  = csr_data[TICK_W-1:0];
            CSR_LONG_PRESS_TICKS:   cfg_in.long_press_ticks   = csr_data[TICK_W-1:0];
            CSR_SHORT_BLINK_TICKS:  cfg_in.short_blink_ticks  = csr_data[TICK_W-1:0];
            CSR_LONG_BLINK_TICKS:   cfg_in.long_blink_ticks   = csr_data[TICK_W-1:0];
            CSR_BLINK_GAP_TICKS:    cfg_in.blink_gap_ticks    = csr_data[TICK_W-1:0];
            CSR_IDLE_TIMEOUT_TICKS: cfg_in.idle_timeout_ticks = csr_data[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.touch_threshold    <= RST_TOUCH_THRESHOLD;
         cfg_ff.short_press_ticks  <= RST_SHORT_PRESS_TICKS;
         cfg_ff.long_press_ticks   <= RST_LONG_PRESS_TICKS;
         cfg_ff.short_blink_ticks  <= RST_SHORT_BLINK_TICKS;
         cfg_ff.long_blink_ticks   <= RST_LONG_BLINK_TICKS;
         cfg_ff.blink_gap_ticks    <= RST_BLINK_GAP_TICKS;
         cfg_ff.idle_timeout_ticks <= RST_IDLE_TIMEOUT_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/tbm_step.sv
// -----------------------------------------------------------------------------
// tbm_step
// Per-sample update: idle timeout, press timing, bank step and blink code.
// -----------------------------------------------------------------------------
module tbm_step #(
   parameter int NUM_BANKS = tbm_pkg::NUM_BANKS_DEF,
   parameter int BANK_W    = $clog2(NUM_BANKS),
   parameter int SHORT_W   = $clog2(2 * NUM_BANKS + 1)
) (
   input  tbm_pkg::cfg_type              cfg,
   input  logic [tbm_pkg::TICK_W-1:0]    now_ticks,
   input  logic [tbm_pkg::TOUCH_W-1:0]   touch_a,
   input  logic [tbm_pkg::TOUCH_W-1:0]   touch_b,
   input  tbm_pkg::core_state_type       st_cur,
   input  logic [BANK_W-1:0]             bank_cur,
   input  logic [SHORT_W-1:0]            short_cur,
   output tbm_pkg::core_state_type       st_nxt,
   output logic [BANK_W-1:0]             bank_nxt,
   output logic [SHORT_W-1:0]            short_nxt,
   output tbm_pkg::result_type           result
);
   import tbm_pkg::*;

   logic               btn_a;
   logic               btn_b;
   logic [TICK_W-1:0]  idle_dt;
   logic [TICK_W-1:0]  press_dt;
   logic [TICK_W-1:0]  blink_dt;
   logic [TICK_W-1:0]  gap_dt;
   logic               mark_moved;
   cmd_type            cmd;
   logic [BANK_W-1:0]  cmd_bank;
   logic [1:0]         longs;
   logic [SHORT_W-1:0] shorts;

   assign btn_a    = touch_a > cfg.touch_threshold;
   assign btn_b    = touch_b > cfg.touch_threshold;
   assign idle_dt  = now_ticks - st_cur.last_activity;
   assign press_dt = now_ticks - st_cur.press_a_start;
   assign blink_dt = now_ticks - st_cur.blink_mark;

   always_comb begin
      st_nxt     = st_cur;
      bank_nxt   = bank_cur;
      short_nxt  = short_cur;
      cmd        = CMD_NONE;
      cmd_bank   = '0;
      mark_moved = 1'b0;
      longs      = 2'd0;
      shorts     = '0;
      gap_dt     = '0;

      if (idle_dt > cfg.idle_timeout_ticks) begin
         st_nxt.mode          = MODE_IDLE;
         bank_nxt             = '0;
         st_nxt.last_activity = now_ticks;
      end

      // button A: time the press on release
      if (btn_a) begin
         if (!st_cur.press_a_down) begin
            st_nxt.press_a_down  = 1'b1;
            st_nxt.press_a_start = now_ticks;
         end
      end else if (st_cur.press_a_down) begin
         st_nxt.press_a_down = 1'b0;
         if (press_dt >= cfg.short_press_ticks && press_dt < cfg.long_press_ticks) begin
            if (st_nxt.mode == MODE_LOAD || st_nxt.mode == MODE_STORE) begin
               cmd         = cmd_type'(st_nxt.mode);
               cmd_bank    = bank_nxt;
               st_nxt.mode = MODE_IDLE;
            end
         end else if (press_dt >= cfg.long_press_ticks) begin
            case (st_nxt.mode)
               MODE_IDLE:  st_nxt.mode = MODE_LOAD;
               MODE_LOAD:  st_nxt.mode = MODE_STORE;
               MODE_STORE: st_nxt.mode = MODE_IDLE;
               default:    st_nxt.mode = MODE_LOAD;
            endcase
            bank_nxt = '0;
         end
         st_nxt.last_activity = now_ticks;
      end

      // button B: bank step on release, only outside idle mode
      if (st_nxt.mode != MODE_IDLE) begin
         if (st_cur.press_b_prev && !btn_b) begin
            bank_nxt = (bank_nxt == BANK_W'(NUM_BANKS - 1)) ? '0 : bank_nxt + 1'b1;
            st_nxt.last_activity = now_ticks;
         end
         st_nxt.press_b_prev = btn_b;
      end

      // blink advance
      if (st_cur.blink_active) begin
         if (st_cur.long_left != '0) begin
            if (blink_dt >= cfg.long_blink_ticks) begin
               st_nxt.led_level  = !st_cur.led_level;
               st_nxt.blink_mark = now_ticks;
               st_nxt.long_left  = st_cur.long_left - 1'b1;
               mark_moved        = 1'b1;
            end
         end else if (short_cur != '0) begin
            if (blink_dt >= cfg.short_blink_ticks) begin
               st_nxt.led_level  = !st_cur.led_level;
               st_nxt.blink_mark = now_ticks;
               short_nxt         = short_cur - 1'b1;
               mark_moved        = 1'b1;
            end
         end
         if (st_nxt.long_left == '0 && short_nxt == '0 && !st_nxt.led_level) begin
            st_nxt.blink_active = 1'b0;
            st_nxt.blink_mark   = now_ticks;
            mark_moved          = 1'b1;
         end
      end

      // new code once the gap has passed
      gap_dt = mark_moved ? '0 : blink_dt;
      if (!st_nxt.blink_active && gap_dt >= cfg.blink_gap_ticks) begin
         case (st_nxt.mode)
            MODE_IDLE: begin
               longs  = 2'd0;
               shorts = SHORT_W'(1);
            end
            MODE_LOAD, MODE_STORE: begin
               longs  = st_nxt.mode;
               shorts = SHORT_W'(bank_nxt) + SHORT_W'(1);
            end
            default: begin
               longs  = 2'd0;
               shorts = SHORT_W'(bank_nxt) + SHORT_W'(1);
            end
         endcase
         st_nxt.long_left    = {longs, 1'b0};
         short_nxt           = shorts << 1;
         st_nxt.blink_mark   = now_ticks;
         st_nxt.blink_active = 1'b1;
         st_nxt.led_level    = 1'b0;
      end
   end

   assign result.led_on        = st_nxt.led_level;
   assign result.transfer_cmd  = cmd;
   assign result.transfer_bank = OUT_BANK_W'(cmd_bank);
   assign result.cur_mode      = st_nxt.mode;
   assign result.cur_bank      = OUT_BANK_W'(bank_nxt);

endmodule

>>> rtl/core/two_button_mode_ui_with_blink_code.sv
// A sample accepted into the sample register goes through a single state-update pass into
// the result register once that is empty or being read. Throughput: one sample per cycle
// while the result is not stalled. A stalled result holds at most one more beat.
// Reset (synchronous, active high) clears all state, both stage valids and
// restores every configuration register to its default.
// -----------------------------------------------------------------------------
// two_button_mode_ui_with_blink_code
// Touch-button mode selector issuing load/store commands with an LED code.
// -----------------------------------------------------------------------------
module two_button_mode_ui_with_blink_code #(
   parameter int NUM_BANKS = tbm_pkg::NUM_BANKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   tbm_req_if.sink                         req_ch,
   tbm_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [tbm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tbm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import tbm_pkg::*;

   localparam int BANK_W  = $clog2(NUM_BANKS);
   localparam int SHORT_W = $clog2(2 * NUM_BANKS + 1);

   cfg_type            cfg;

   logic               in_valid_ff;
   logic               in_valid_in;
   logic [TICK_W-1:0]  in_now_ff;
   logic [TOUCH_W-1:0] in_touch_a_ff;
   logic [TOUCH_W-1:0] in_touch_b_ff;

   core_state_type     state_ff;
   core_state_type     state_in;
   logic [BANK_W-1:0]  bank_ff;
   logic [BANK_W-1:0]  bank_in;
   logic [SHORT_W-1:0] short_ff;
   logic [SHORT_W-1:0] short_in;

   result_type         step_res;
   result_type         out_ff;
   logic               out_valid_ff;
   logic               out_valid_in;

   logic               advance;
   logic               req_take;

   tbm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tbm_step #(
      .NUM_BANKS (NUM_BANKS),
      .BANK_W    (BANK_W),
      .SHORT_W   (SHORT_W)
   ) u_step (
      .cfg       (cfg),
      .now_ticks (in_now_ff),
      .touch_a   (in_touch_a_ff),
      .touch_b   (in_touch_b_ff),
      .st_cur    (state_ff),
      .bank_cur  (bank_ff),
      .short_cur (short_ff),
      .st_nxt    (state_in),
      .bank_nxt  (bank_in),
      .short_nxt (short_in),
      .result    (step_res)
   );

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         bank_ff      <= '0;
         short_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
            bank_ff  <= bank_in;
            short_ff <= short_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_now_ff     <= req_ch.now_ticks;
         in_touch_a_ff <= req_ch.touch_a;
         in_touch_b_ff <= req_ch.touch_b;
      end
      if (advance) begin
         out_ff <= step_res;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.led_on        = out_ff.led_on;
   assign rsp_ch.transfer_cmd  = out_ff.transfer_cmd;
   assign rsp_ch.transfer_bank = out_ff.transfer_bank;
   assign rsp_ch.cur_mode      = out_ff.cur_mode;
   assign rsp_ch.cur_bank      = out_ff.cur_bank;

endmodule

>>> rtl/core/tbm_checker.sv
// -----------------------------------------------------------------------------
// tbm_checker
// Port-level checks on the result channel of the mode UI.
// -----------------------------------------------------------------------------
module tbm_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               led_on,
   input logic [tbm_pkg::CMD_W-1:0]          transfer_cmd,
   input logic [tbm_pkg::OUT_BANK_W-1:0]     transfer_bank,
   input logic [tbm_pkg::MODE_W-1:0]         cur_mode,
   input logic [tbm_pkg::OUT_BANK_W-1:0]     cur_bank
);
   import tbm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(led_on) && $stable(transfer_cmd)
         && $stable(transfer_bank) && $stable(cur_mode) && $stable(cur_bank))
      else $error("result beat changed while stalled");

   a_cmd_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && transfer_cmd != CMD_NONE |-> cur_mode == MODE_IDLE)
      else $error("command issued without return to idle mode");

   a_no_cmd_no_bank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && transfer_cmd == CMD_NONE |-> transfer_bank == '0)
      else $error("transfer bank set without command");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat valid right after reset");

endmodule

bind two_button_mode_ui_with_blink_code tbm_checker u_tbm_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .led_on        (rsp_ch.led_on),
   .transfer_cmd  (rsp_ch.transfer_cmd),
   .transfer_bank (rsp_ch.transfer_bank),
   .cur_mode      (rsp_ch.cur_mode),
   .cur_bank      (rsp_ch.cur_bank)
);
